// File: hw/rtl/baro_sensor_compensation_defines.svh
// assertion macros for the barometric compensation block
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsc check failed");
// next-cycle implication
`define BSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsc check failed");
`else
`define BSC_ASSERT_NOW(label, ante, cons)
`define BSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/bsc_pkg.sv
`default_nettype none
package bsc_pkg;

  typedef enum logic [2:0] {
    REG_AC1_AC2  = 3'd0,
    REG_AC3_AC4  = 3'd1,
    REG_AC5_AC6  = 3'd2,
    REG_B1_B2    = 3'd3,
    REG_MC_MD    = 3'd4,
    REG_OSS      = 3'd5
  } reg_idx_t;

  localparam logic [1:0]   OSS_RESET   = 2'd2;
  localparam logic [31:0]  B6_OFFSET   = 32'd4000;
  localparam logic [31:0]  B4_OFFSET   = 32'd32768;
  localparam logic [15:0]  B7_SCALE    = 16'd50000;
  localparam logic [31:0]  SIGN_BIT    = 32'h8000_0000;
  localparam logic [31:0]  P_C1        = 32'd3038;
  localparam logic [31:0]  P_C2        = 32'hFFFF_E343;
  localparam logic [31:0]  P_C3        = 32'd3791;
  localparam logic signed [10:0] T_MIN = -11'sd400;
  localparam logic signed [10:0] T_MAX = 11'sd850;
  localparam logic [16:0]  P_MAX       = 17'h1FFFF;

endpackage
`default_nettype wire

// File: hw/rtl/baro_sensor_compensation.sv
`default_nettype none
// channel   signals                                       direction
// input     in_valid/in_ready, raw_temp, raw_pressure       in
// output    out_valid/out_ready, temp_tenths, pressure_pa,  out
//           fault
// config    psel/penable/pwrite/paddr/pwdata/prdata/pready  apb
//
// one sample pair accepted per cycle while the pipeline advances; the path runs through
// 27 stages of the temperature divider, 32 of the pressure divider and 13 others
// the whole pipeline advances together: it moves when the output register is
// empty or its transaction completes, and holds every stage otherwise
// rst clears all valid bits and the configuration registers (oversampling to 2)
module baro_sensor_compensation (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        raw_temp,
  input  wire logic [23:0]        raw_pressure,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [10:0]      temp_tenths,
  output logic [16:0]             pressure_pa,
  output logic                    fault,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int TDW = 27;
  localparam int TSW = 32 + 1 + 1 + 19;
  localparam int PSW = 11 + 1 + 1;

  // configuration registers
  logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;
  logic [1:0]  oversampling;
  logic [2:0]  widx;

  assign pready = 1'b1;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2  <= '0;
      cal_ac3_ac4  <= '0;
      cal_ac5_ac6  <= '0;
      cal_b1_b2    <= '0;
      cal_mc_md    <= '0;
      oversampling <= bsc_pkg::OSS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        bsc_pkg::REG_AC1_AC2: cal_ac1_ac2  <= pwdata;
        bsc_pkg::REG_AC3_AC4: cal_ac3_ac4  <= pwdata;
        bsc_pkg::REG_AC5_AC6: cal_ac5_ac6  <= pwdata;
        bsc_pkg::REG_B1_B2:   cal_b1_b2    <= pwdata;
        bsc_pkg::REG_MC_MD:   cal_mc_md    <= pwdata;
        bsc_pkg::REG_OSS:     oversampling <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      bsc_pkg::REG_AC1_AC2: prdata = cal_ac1_ac2;
      bsc_pkg::REG_AC3_AC4: prdata = cal_ac3_ac4;
      bsc_pkg::REG_AC5_AC6: prdata = cal_ac5_ac6;
      bsc_pkg::REG_B1_B2:   prdata = cal_b1_b2;
      bsc_pkg::REG_MC_MD:   prdata = cal_mc_md;
      bsc_pkg::REG_OSS:     prdata = {30'd0, oversampling};
      default:              prdata = '0;
    endcase
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = cal_ac1_ac2[31:16];
  assign ac2 = cal_ac1_ac2[15:0];
  assign ac3 = cal_ac3_ac4[31:16];
  assign ac4 = cal_ac3_ac4[15:0];
  assign ac5 = cal_ac5_ac6[31:16];
  assign ac6 = cal_ac5_ac6[15:0];
  assign b1  = cal_b1_b2[31:16];
  assign b2  = cal_b1_b2[15:0];
  assign mc  = cal_mc_md[31:16];
  assign md  = cal_mc_md[15:0];

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: raw temperature product, raw pressure shift
  logic               v1;
  logic signed [31:0] s1_prod;
  logic [18:0]        s1_up;
  logic signed [16:0] ut_diff;
  logic [23:0]        up_full;

  always_comb begin
    ut_diff = $signed({1'b0, raw_temp}) - $signed({1'b0, ac6});
    up_full = raw_pressure >> (4'd8 - {2'b00, oversampling});
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= 32'(ut_diff * $signed({1'b0, ac5}));
      s1_up   <= up_full[18:0];
    end
  end

  // stage 2: x1 and divisor
  logic               v2;
  logic signed [31:0] s2_x1, s2_d;
  logic [18:0]        s2_up;
  logic signed [31:0] x1_t;

  assign x1_t = s1_prod >>> 15;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x1 <= x1_t;
      s2_d  <= x1_t + 32'(md);
      s2_up <= s1_up;
    end
  end

  // temperature division on magnitudes
  logic signed [31:0] mc_sh, mc_abs;
  logic [31:0]        d_abs;
  logic               t_neg, t_zero;
  logic [TSW-1:0]     tside_in, tside_out;
  logic               td_vld;
  logic [TDW-1:0]     tq;

  always_comb begin
    mc_sh    = 32'(mc) <<< 11;
    mc_abs   = mc_sh[31] ? -mc_sh : mc_sh;
    d_abs    = s2_d[31] ? 32'(-s2_d) : 32'(s2_d);
    t_neg    = mc_sh[31] ^ s2_d[31];
    t_zero   = (s2_d == 32'sd0);
    tside_in = {s2_x1, t_neg, t_zero, s2_up};
  end

  bsc_div #(.DW(TDW), .VW(32), .SW(TSW)) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v2),
    .dividend (mc_abs[TDW-1:0]),
    .divisor  (d_abs),
    .side_in  (tside_in),
    .out_vld  (td_vld),
    .quotient (tq),
    .side_out (tside_out)
  );

  // stage 3: b5
  logic               v3, s3_fault;
  logic signed [31:0] s3_b5;
  logic [18:0]        s3_up;
  logic signed [31:0] tq_s, x1_d;

  always_comb begin
    tq_s = tside_out[20] ? -$signed({5'd0, tq}) : $signed({5'd0, tq});
    x1_d = tside_out[TSW-1 -: 32];
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= td_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_b5    <= x1_d + tq_s;
      s3_fault <= tside_out[19];
      s3_up    <= tside_out[18:0];
    end
  end

  // stage 4: temperature and b6
  logic               v4, s4_fault;
  logic signed [31:0] s4_b6;
  logic signed [10:0] s4_t;
  logic [18:0]        s4_up;
  logic signed [31:0] t_full;

  assign t_full = (s3_b5 + 32'sd8) >>> 4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_b6 <= s3_b5 - $signed(bsc_pkg::B6_OFFSET);
      if (t_full < 32'(bsc_pkg::T_MIN)) s4_t <= bsc_pkg::T_MIN;
      else if (t_full > 32'(bsc_pkg::T_MAX)) s4_t <= bsc_pkg::T_MAX;
      else s4_t <= t_full[10:0];
      s4_fault <= s3_fault;
      s4_up    <= s3_up;
    end
  end

  // stage 5: b6 squared
  logic               v5, s5_fault;
  logic signed [31:0] s5_b6, s5_sq;
  logic signed [10:0] s5_t;
  logic [18:0]        s5_up;
  logic signed [31:0] sq_prod;

  assign sq_prod = s4_b6 * s4_b6;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sq    <= sq_prod >>> 12;
      s5_b6    <= s4_b6;
      s5_t     <= s4_t;
      s5_fault <= s4_fault;
      s5_up    <= s4_up;
    end
  end

  // stage 6: coefficient products
  logic               v6, s6_fault;
  logic signed [31:0] s6_m1, s6_m2, s6_m3, s6_m4;
  logic signed [10:0] s6_t;
  logic [18:0]        s6_up;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_m1    <= 32'(b2) * s5_sq;
      s6_m2    <= 32'(ac2) * s5_b6;
      s6_m3    <= 32'(ac3) * s5_b6;
      s6_m4    <= 32'(b1) * s5_sq;
      s6_t     <= s5_t;
      s6_fault <= s5_fault;
      s6_up    <= s5_up;
    end
  end

  // stage 7: b3 and the b4 term
  logic               v7, s7_fault;
  logic signed [31:0] s7_b3, s7_x3;
  logic signed [10:0] s7_t;
  logic [18:0]        s7_up;
  logic signed [31:0] x3a, b3a, x3b;

  always_comb begin
    x3a = (s6_m1 >>> 11) + (s6_m2 >>> 11);
    b3a = ((32'(ac1) <<< 2) + x3a) <<< oversampling;
    x3b = ((s6_m3 >>> 13) + (s6_m4 >>> 16) + 32'sd2) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_b3    <= (b3a + 32'sd2) >>> 2;
      s7_x3    <= x3b;
      s7_t     <= s6_t;
      s7_fault <= s6_fault;
      s7_up    <= s6_up;
    end
  end

  // stage 8: b4 product, up - b3
  logic        v8, s8_fault;
  logic [31:0] s8_b4p, s8_upd;
  logic signed [10:0] s8_t;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_b4p   <= {16'd0, ac4} * (32'(s7_x3) + bsc_pkg::B4_OFFSET);
      s8_upd   <= {13'd0, s7_up} - 32'(s7_b3);
      s8_t     <= s7_t;
      s8_fault <= s7_fault;
    end
  end

  // stage 9: b4 and b7
  logic        v9, s9_fault;
  logic [16:0] s9_b4;
  logic [31:0] s9_b7;
  logic signed [10:0] s9_t;
  logic [16:0] b4_w;

  assign b4_w = s8_b4p[31:15];

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_b4    <= b4_w;
      s9_b7    <= s8_upd * {16'd0, bsc_pkg::B7_SCALE >> oversampling};
      s9_t     <= s8_t;
      s9_fault <= s8_fault || (b4_w == 17'd0);
    end
  end

  // pressure division: doubled b7 when it fits, else double the quotient
  logic           p_big;
  logic [31:0]    p_num;
  logic [PSW-1:0] pside_in, pside_out;
  logic           pd_vld;
  logic [31:0]    pq;

  always_comb begin
    p_big    = (s9_b7 >= bsc_pkg::SIGN_BIT);
    p_num    = p_big ? s9_b7 : {s9_b7[30:0], 1'b0};
    pside_in = {s9_t, s9_fault, p_big};
  end

  bsc_div #(.DW(32), .VW(17), .SW(PSW)) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v9),
    .dividend (p_num),
    .divisor  (s9_b4),
    .side_in  (pside_in),
    .out_vld  (pd_vld),
    .quotient (pq),
    .side_out (pside_out)
  );

  // stage 10: p
  logic               v10, s10_fault;
  logic signed [31:0] s10_p;
  logic signed [10:0] s10_t;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= pd_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_p     <= pside_out[0] ? {pq[30:0], 1'b0} : pq;
      s10_t     <= pside_out[PSW-1 -: 11];
      s10_fault <= pside_out[1];
    end
  end

  // stage 11: p squared term and linear term
  logic               v11, s11_fault;
  logic signed [31:0] s11_sq, s11_lin, s11_p;
  logic signed [10:0] s11_t;
  logic signed [31:0] p8;

  assign p8 = s10_p >>> 8;

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_sq    <= p8 * p8;
      s11_lin   <= $signed(bsc_pkg::P_C2) * s10_p;
      s11_p     <= s10_p;
      s11_t     <= s10_t;
      s11_fault <= s10_fault;
    end
  end

  // stage 12: scaled correction terms
  logic               v12, s12_fault;
  logic signed [31:0] s12_x1, s12_x2, s12_p;
  logic signed [10:0] s12_t;
  logic signed [31:0] x1_p;

  assign x1_p = s11_sq * $signed(bsc_pkg::P_C1);

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= v11;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s12_x1    <= x1_p >>> 16;
      s12_x2    <= s11_lin >>> 16;
      s12_p     <= s11_p;
      s12_t     <= s11_t;
      s12_fault <= s11_fault;
    end
  end

  // stage 13: output register with saturation
  logic signed [31:0] p_fin;

  assign p_fin = s12_p + ((s12_x1 + s12_x2 + $signed(bsc_pkg::P_C3)) >>> 4);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v12;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fault <= s12_fault;
      if (s12_fault) begin
        temp_tenths <= '0;
        pressure_pa <= '0;
      end else begin
        temp_tenths <= s12_t;
        if (p_fin < 32'sd0) pressure_pa <= '0;
        else if (p_fin > $signed({15'd0, bsc_pkg::P_MAX})) pressure_pa <= bsc_pkg::P_MAX;
        else pressure_pa <= p_fin[16:0];
      end
    end
  end

`include "baro_sensor_compensation_defines.svh"

  `BSC_ASSERT_NOW(a_fault_zero, out_valid && fault, temp_tenths == 11'sd0 && pressure_pa == 17'd0)
  `BSC_ASSERT_NOW(a_temp_range, out_valid && !fault, temp_tenths >= bsc_pkg::T_MIN && temp_tenths <= bsc_pkg::T_MAX)
  `BSC_ASSERT_NOW(a_ready_tracks_out, 1'b1, in_ready == (!out_valid || out_ready))
  `BSC_ASSERT_NEXT(a_stall_holds_stage, out_valid && !out_ready && v12, v12 && out_valid)

endmodule
`default_nettype wire

// File: hw/rtl/bsc_div.sv
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
module bsc_div #(
  parameter int DW = 32,
  parameter int VW = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  input  wire logic [SW-1:0] side_in,
  output logic               out_vld,
  output logic [DW-1:0]      quotient,
  output logic [SW-1:0]      side_out
);

  logic [DW:0]   vld;
  logic [VW-1:0] rem [DW+1];
  logic [DW-1:0] aq  [DW+1];
  logic [VW-1:0] dv  [DW+1];
  logic [SW-1:0] sd  [DW+1];

  assign vld[0] = in_vld;
  assign rem[0] = '0;
  assign aq[0]  = dividend;
  assign dv[0]  = divisor;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem[k], aq[k][DW-1]};
      diff  = trial - {1'b0, dv[k]};
      ge    = (trial >= {1'b0, dv[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[VW-1:0] : trial[VW-1:0];
        aq[k+1]  <= {aq[k][DW-2:0], ge};
        dv[k+1]  <= dv[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_vld  = vld[DW];
  assign quotient = aq[DW];
  assign side_out = sd[DW];

endmodule
`default_nettype wire
